[hw/rtl/disjoint_interval_set_assert.svh]
// Assertion macros used by the checker of the interval set.
`ifndef DISJOINT_INTERVAL_SET_ASSERT_SVH
`define DISJOINT_INTERVAL_SET_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DIS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("interval set check failed");

// The consequent must hold in the cycle after the antecedent.
`define DIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("interval set check failed");

`endif

[hw/rtl/dis_pkg.sv]
package dis_pkg;

  localparam int Capacity = 16;
  localparam int IdxW = $clog2(Capacity);
  localparam int CntW = $clog2(Capacity + 1);

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_ENTRY  = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;

  localparam logic [2:0] ST_NEW      = 3'd0;
  localparam logic [2:0] ST_EXTENDED = 3'd1;
  localparam logic [2:0] ST_MERGED   = 3'd2;
  localparam logic [2:0] ST_PRESENT  = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [2:0]         status;
    logic signed [31:0] range_start;
    logic signed [31:0] range_end;
    logic [4:0]         interval_count;
    logic               last;
  } out_t;

endpackage

[hw/rtl/disjoint_interval_set.sv]
// Add item: the stored intervals are scanned, entries are shifted when an interval
// is inserted or two merge, and a new or widened interval is written; one result.
// Read item: one result per stored interval; empty gives one. The next item is taken
// in the cycle of the last result. The interval memory has a registered read.
// Synchronous active-low reset empties the set; the memory itself is not cleared.
module disjoint_interval_set (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  dis_pkg::in_t  in_data,
  output logic          out_valid,
  output dis_pkg::out_t out_data
);
  import dis_pkg::*;

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRD  = 4'd1;  // issue read of scanned entry
  localparam logic [3:0] S_SEV  = 4'd2;  // compare scanned entry with the value
  localparam logic [3:0] S_MRD  = 4'd3;  // issue read of entry being moved
  localparam logic [3:0] S_MWR  = 4'd4;  // write moved entry to its new slot
  localparam logic [3:0] S_NEWW = 4'd5;  // write the new single-value interval
  localparam logic [3:0] S_ORD  = 4'd6;  // issue read for readout
  localparam logic [3:0] S_OEV  = 4'd7;  // emit one interval

  // Each memory word holds {start, end} of one interval, lowest first.
  logic [63:0] mem [Capacity];
  logic [63:0] rdata_r;

  logic [3:0]         state_r, state_nxt;
  logic [CntW-1:0]    cnt_r, cnt_nxt;
  logic [CntW-1:0]    i_r, i_nxt;
  logic [CntW-1:0]    pos_r, pos_nxt;
  logic               pos_set_r, pos_set_nxt;
  logic               lft_r, lft_nxt;
  logic               rgt_r, rgt_nxt;
  logic [IdxW-1:0]    lidx_r, lidx_nxt;
  logic [IdxW-1:0]    ridx_r, ridx_nxt;
  logic signed [31:0] lstart_r, lstart_nxt;
  logic signed [31:0] rend_r, rend_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic               up_r, up_nxt;      // moving entries toward higher slots
  logic               ovalid_r, ovalid_nxt;
  out_t               out_r, out_nxt;

  logic               we;
  logic [IdxW-1:0]    waddr, raddr;
  logic [63:0]        wdata;

  logic signed [31:0] rd_start, rd_end;
  logic signed [32:0] v_x, s_m1, e_p1;

  assign rd_start = rdata_r[63:32];
  assign rd_end   = rdata_r[31:0];
  // Adjacency is tested one bit wider so that the integer extremes never wrap.
  assign v_x  = {val_r[31], val_r};
  assign s_m1 = {rd_start[31], rd_start} - 33'sd1;
  assign e_p1 = {rd_end[31], rd_end} + 33'sd1;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = ovalid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    i_nxt       = i_r;
    pos_nxt     = pos_r;
    pos_set_nxt = pos_set_r;
    lft_nxt     = lft_r;
    rgt_nxt     = rgt_r;
    lidx_nxt    = lidx_r;
    ridx_nxt    = ridx_r;
    lstart_nxt  = lstart_r;
    rend_nxt    = rend_r;
    val_nxt     = val_r;
    up_nxt      = up_r;
    ovalid_nxt  = 1'b0;
    out_nxt     = out_r;
    we          = 1'b0;
    waddr       = i_r[IdxW-1:0];
    wdata       = rdata_r;
    raddr       = i_r[IdxW-1:0];

    // An add status result is the most common; fields are refined below.
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          val_nxt     = in_data.value;
          i_nxt       = '0;
          pos_nxt     = cnt_r;
          pos_set_nxt = 1'b0;
          lft_nxt     = 1'b0;
          rgt_nxt     = 1'b0;
          state_nxt   = (in_data.cmd == CMD_READ) ? S_ORD : S_SRD;
        end
      end

      S_SRD: begin
        if (i_r == cnt_r) begin
          // Scan complete: decide what to do with the value.
          ovalid_nxt = 1'b1;
          out_nxt = '{kind: KIND_STATUS, status: ST_EXTENDED, range_start: '0,
                      range_end: '0, interval_count: 5'(cnt_r), last: 1'b1};
          state_nxt = S_IDLE;
          if (lft_r && rgt_r) begin
            we    = 1'b1;
            waddr = lidx_r;
            wdata = {lstart_r, rend_r};
            out_nxt.status = ST_MERGED;
            out_nxt.interval_count = 5'(cnt_r - 1'b1);
            cnt_nxt = cnt_r - 1'b1;
            // Close the hole left by the absorbed right interval.
            up_nxt = 1'b0;
            i_nxt  = CntW'(ridx_r) + 1'b1;
            if (CntW'(ridx_r) + 1'b1 < cnt_r) begin
              state_nxt  = S_MRD;
              ovalid_nxt = 1'b0;
            end
          end else if (lft_r) begin
            we    = 1'b1;
            waddr = lidx_r;
            wdata = {lstart_r, val_r};
          end else if (rgt_r) begin
            we    = 1'b1;
            waddr = ridx_r;
            wdata = {val_r, rend_r};
          end else if (cnt_r == CntW'(Capacity)) begin
            out_nxt.status = ST_FULL;
          end else begin
            ovalid_nxt = 1'b0;
            up_nxt     = 1'b1;
            i_nxt      = cnt_r - 1'b1;
            state_nxt  = (pos_r == cnt_r) ? S_NEWW : S_MRD;
          end
        end else begin
          state_nxt = S_SEV;
        end
      end

      S_SEV: begin
        if (val_r >= rd_start && val_r <= rd_end) begin
          ovalid_nxt = 1'b1;
          out_nxt = '{kind: KIND_STATUS, status: ST_PRESENT, range_start: '0,
                      range_end: '0, interval_count: 5'(cnt_r), last: 1'b1};
          state_nxt = S_IDLE;
        end else begin
          if (e_p1 == v_x) begin
            lft_nxt    = 1'b1;
            lidx_nxt   = i_r[IdxW-1:0];
            lstart_nxt = rd_start;
          end
          if (s_m1 == v_x) begin
            rgt_nxt  = 1'b1;
            ridx_nxt = i_r[IdxW-1:0];
            rend_nxt = rd_end;
          end
          if (!pos_set_r && rd_start > val_r) begin
            pos_set_nxt = 1'b1;
            pos_nxt     = i_r;
          end
          i_nxt     = i_r + 1'b1;
          state_nxt = S_SRD;
        end
      end

      S_MRD: begin
        state_nxt = S_MWR;
      end

      S_MWR: begin
        we = 1'b1;
        if (up_r) begin
          waddr = IdxW'(i_r + 1'b1);
          if (i_r == pos_r) begin
            state_nxt = S_NEWW;
          end else begin
            i_nxt     = i_r - 1'b1;
            state_nxt = S_MRD;
          end
        end else begin
          waddr = IdxW'(i_r - 1'b1);
          if (i_r + 1'b1 == cnt_r + 1'b1 || i_r + 1'b1 > cnt_r) begin
            // cnt_r already holds the merged count; the last moved entry was
            // the old top one.
            ovalid_nxt = 1'b1;
            out_nxt = '{kind: KIND_STATUS, status: ST_MERGED, range_start: '0,
                        range_end: '0, interval_count: 5'(cnt_r), last: 1'b1};
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_MRD;
          end
        end
      end

      S_NEWW: begin
        we    = 1'b1;
        waddr = pos_r[IdxW-1:0];
        wdata = {val_r, val_r};
        cnt_nxt = cnt_r + 1'b1;
        ovalid_nxt = 1'b1;
        out_nxt = '{kind: KIND_STATUS, status: ST_NEW, range_start: '0,
                    range_end: '0, interval_count: 5'(cnt_r + 1'b1), last: 1'b1};
        state_nxt = S_IDLE;
      end

      S_ORD: begin
        if (cnt_r == '0) begin
          ovalid_nxt = 1'b1;
          out_nxt = '{kind: KIND_EMPTY, status: ST_NEW, range_start: '0,
                      range_end: '0, interval_count: '0, last: 1'b1};
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_OEV;
        end
      end

      S_OEV: begin
        ovalid_nxt = 1'b1;
        out_nxt = '{kind: KIND_ENTRY, status: ST_NEW, range_start: rd_start,
                    range_end: rd_end, interval_count: 5'(cnt_r),
                    last: (i_r + 1'b1 == cnt_r)};
        if (i_r + 1'b1 == cnt_r) begin
          state_nxt = S_IDLE;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_ORD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
    i_r       <= i_nxt;
    pos_r     <= pos_nxt;
    pos_set_r <= pos_set_nxt;
    lft_r     <= lft_nxt;
    rgt_r     <= rgt_nxt;
    lidx_r    <= lidx_nxt;
    ridx_r    <= ridx_nxt;
    lstart_r  <= lstart_nxt;
    rend_r    <= rend_nxt;
    val_r     <= val_nxt;
    up_r      <= up_nxt;
    out_r     <= out_nxt;
  end

endmodule

[hw/rtl/dis_check.sv]
`include "disjoint_interval_set_assert.svh"

module dis_check (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_valid,
  input dis_pkg::out_t out_data
);
  import dis_pkg::*;

  logic is_status;
  logic is_empty;
  logic is_entry;

  assign is_status = out_valid && out_data.kind == KIND_STATUS;
  assign is_empty  = out_valid && out_data.kind == KIND_EMPTY;
  assign is_entry  = out_valid && out_data.kind == KIND_ENTRY;

  // An accepted item always makes the block busy.
  `DIS_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  // An add yields exactly one result, so its status is always the last one.
  `DIS_ASSERT_SAME(a_status_last, clk, rst_n, is_status, out_data.last)
  // The empty marker only appears when nothing is stored.
  `DIS_ASSERT_SAME(a_empty_zero, clk, rst_n, is_empty, out_data.interval_count == 5'd0 && out_data.last)
  // Stored intervals are never inverted.
  `DIS_ASSERT_SAME(a_entry_order, clk, rst_n, is_entry, out_data.range_start <= out_data.range_end)

endmodule

bind disjoint_interval_set dis_check u_dis_check (.*);
